// ===== src/endpoint_corner_merger_defines.svh =====
// Assertion macros shared by the endpoint corner merger RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ENDPOINT_CORNER_MERGER_DEFINES_SVH
`define ENDPOINT_CORNER_MERGER_DEFINES_SVH

// A condition that must hold at every clock edge.
`define ECM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ECM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ECM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ecm_pkg.sv =====
`default_nettype none

package ecm_pkg;

    localparam int MAX_CORNERS_DEF = 16;

    localparam int COORD_W  = 16;
    localparam int RANGE_W  = 24;
    localparam int RADIUS_W = 13;
    localparam int ROOT_W   = 16;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int PROD_W   = 2 * (COORD_W + 1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd307;
    localparam logic [RANGE_W-1:0]  RANGE_MAX    = '1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [RANGE_W-1:0]        t_range;
    typedef logic [RADIUS_W-1:0]       t_radius;
    typedef logic [ROOT_W-1:0]         t_root;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_range sum;
    } t_corner;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_R2L,
        ST_MX,
        ST_MY,
        ST_MS,
        ST_SQRT,
        ST_RD,
        ST_CMP,
        ST_WB,
        ST_APP,
        ST_ORD,
        ST_OWAIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/ecm_if.sv =====
`default_nettype none

// Segment channel: one beat carries one line segment.
interface ecm_seg_if;
    logic             valid;
    logic             ready;
    ecm_pkg::t_coord  start_x;
    ecm_pkg::t_coord  start_y;
    ecm_pkg::t_coord  end_x;
    ecm_pkg::t_coord  end_y;
    logic             no_segment;
    logic             last_segment;

    modport source (
        output valid, start_x, start_y, end_x, end_y, no_segment, last_segment,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, no_segment, last_segment,
        output ready
    );
endinterface

// Configuration channel: one beat writes the merge radius.
interface ecm_cfg_if;
    logic             valid;
    logic             ready;
    ecm_pkg::t_radius merge_radius;

    modport source (output valid, merge_radius, input ready);
    modport sink (input valid, merge_radius, output ready);
endinterface

// Corner channel: one beat carries one merged corner.
interface ecm_corner_if;
    logic             valid;
    logic             ready;
    ecm_pkg::t_coord  corner_x;
    ecm_pkg::t_coord  corner_y;
    ecm_pkg::t_range  range_sum;
    logic             last_corner;
    logic             frame_empty;
    logic             table_overflow;

    modport source (
        output valid, corner_x, corner_y, range_sum, last_corner, frame_empty,
        table_overflow,
        input  ready
    );
    modport sink (
        input  valid, corner_x, corner_y, range_sum, last_corner, frame_empty,
        table_overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/endpoint_corner_merger.sv =====
// Endpoint corner merger. Each segment beat carries two endpoints in signed Q5.10 metres;
// each endpoint is tested against every corner already held in the table, in table order,
// the start point before the end point, and a corner closer than merge_radius moves to the
// floored midpoint and adds the endpoint's range from the origin to its saturating range
// sum. An endpoint that matches no corner is appended, or sets the overflow flag when the
// table is full. The beat marked last_segment then streams out every corner, or a single
// frame_empty beat, and clears the table. The block works on one segment at a time and
// holds ready low meanwhile. Its cost grows with the number of corners stored when a
// segment arrives; it is set by one shared 17x17 multiplier that forms every squared
// distance in turn and by a bit-serial square root that forms the sixteen result bits of
// each endpoint range and then hands the root back. Each corner beat is loaded into the
// output register in ST_ORD and held in ST_OWAIT until the sink takes it. A no_segment
// beat without last_segment is taken in idle and leaves the block idle. The radius may be
// written whenever the block is idle.
`default_nettype none

`include "endpoint_corner_merger_defines.svh"

module endpoint_corner_merger #(
    parameter int MAX_CORNERS = ecm_pkg::MAX_CORNERS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ecm_seg_if.sink       i_seg,
    ecm_cfg_if.sink       i_cfg,
    ecm_corner_if.source  o_corner
);

    localparam int IW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CORNERS);
    localparam int R2_W = 2 * ecm_pkg::RADIUS_W;
    localparam int CX_W = ecm_pkg::COORD_W + 1;

    // Control state.
    ecm_pkg::t_state  r_state;
    ecm_pkg::t_state  n_state;
    ecm_pkg::t_radius r_radius;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_j;
    logic             r_pt;
    logic             r_rng_mode;
    logic             r_hit_s;
    logic             r_hit_e;
    logic             r_ovf;
    logic             r_last;

    // Datapath registers.
    ecm_pkg::t_coord             r_sx;
    ecm_pkg::t_coord             r_sy;
    ecm_pkg::t_coord             r_ex;
    ecm_pkg::t_coord             r_ey;
    logic [R2_W-1:0]             r_r2;
    logic signed [ecm_pkg::PROD_W-1:0] r_prod;
    logic [ecm_pkg::PROD_W-1:0]  r_acc;
    ecm_pkg::t_coord             r_cx;
    ecm_pkg::t_coord             r_cy;
    ecm_pkg::t_range             r_cs;
    ecm_pkg::t_root              r_rng_s;
    ecm_pkg::t_root              r_rng_e;
    ecm_pkg::t_corner            r_mem [MAX_CORNERS];

    ecm_pkg::t_coord             r_o_x;
    ecm_pkg::t_coord             r_o_y;
    ecm_pkg::t_range             r_o_sum;
    logic                        r_o_last;
    logic                        r_o_empty;
    logic                        r_o_ovf;

    // Combinational datapath.
    ecm_pkg::t_coord             pt_x;
    ecm_pkg::t_coord             pt_y;
    ecm_pkg::t_coord             base_x;
    ecm_pkg::t_coord             base_y;
    logic signed [CX_W-1:0]      dx;
    logic signed [CX_W-1:0]      dy;
    logic signed [CX_W-1:0]      mul_op;
    logic [ecm_pkg::PROD_W-1:0]  sq_sum;
    logic                        hit;
    logic signed [CX_W-1:0]      mid_sx;
    logic signed [CX_W-1:0]      mid_sy;
    ecm_pkg::t_root              rng_pt;
    logic [ecm_pkg::RANGE_W:0]   sum_ext;
    ecm_pkg::t_range             sat_sum;
    logic                        hit_pt;
    logic                        seg_beat;
    logic                        out_beat;
    logic                        last_j;
    logic                        sq_start;
    logic                        sq_done;
    ecm_pkg::t_root              sq_root;

    assign seg_beat = i_seg.valid && i_seg.ready;
    assign out_beat = o_corner.valid && o_corner.ready;

    always_comb begin
        pt_x    = r_pt ? r_ex : r_sx;
        pt_y    = r_pt ? r_ey : r_sy;
        // Ranges are distances to the origin, so the corner operand drops out.
        base_x  = r_rng_mode ? '0 : r_cx;
        base_y  = r_rng_mode ? '0 : r_cy;
        dx      = CX_W'(base_x) - CX_W'(pt_x);
        dy      = CX_W'(base_y) - CX_W'(pt_y);
        sq_sum  = r_acc + unsigned'(r_prod);
        hit     = (r_acc < ecm_pkg::PROD_W'(r_r2));
        mid_sx  = CX_W'(r_cx) + CX_W'(pt_x);
        mid_sy  = CX_W'(r_cy) + CX_W'(pt_y);
        rng_pt  = r_pt ? r_rng_e : r_rng_s;
        sum_ext = {1'b0, r_cs} + (ecm_pkg::RANGE_W + 1)'(rng_pt);
        sat_sum = sum_ext[ecm_pkg::RANGE_W] ? ecm_pkg::RANGE_MAX
                                            : sum_ext[ecm_pkg::RANGE_W-1:0];
        hit_pt  = r_pt ? r_hit_e : r_hit_s;
        last_j  = (r_j == (r_n - CW'(1)));
    end

    // The one multiplier squares whichever operand the sequencer selects.
    always_comb begin
        unique case (r_state)
            ecm_pkg::ST_R2: mul_op = signed'(CX_W'(r_radius));
            ecm_pkg::ST_MY: mul_op = dy;
            default:        mul_op = dx;
        endcase
    end

    ecm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_sum[ecm_pkg::SQ_W-1:0]),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ecm_pkg::ST_IDLE: begin
                if (i_seg.valid) begin
                    if (!i_seg.no_segment) begin
                        n_state = ecm_pkg::ST_R2;
                    end else if (i_seg.last_segment) begin
                        n_state = ecm_pkg::ST_ORD;
                    end
                end
            end
            ecm_pkg::ST_R2:  n_state = ecm_pkg::ST_R2L;
            ecm_pkg::ST_R2L: n_state = ecm_pkg::ST_MX;
            ecm_pkg::ST_MX:  n_state = ecm_pkg::ST_MY;
            ecm_pkg::ST_MY:  n_state = ecm_pkg::ST_MS;
            ecm_pkg::ST_MS:  n_state = r_rng_mode ? ecm_pkg::ST_SQRT : ecm_pkg::ST_CMP;
            ecm_pkg::ST_SQRT: begin
                if (sq_done) begin
                    if (!r_pt) begin
                        n_state = ecm_pkg::ST_MX;
                    end else if (r_n == '0) begin
                        n_state = ecm_pkg::ST_APP;
                    end else begin
                        n_state = ecm_pkg::ST_RD;
                    end
                end
            end
            ecm_pkg::ST_RD:  n_state = ecm_pkg::ST_MX;
            ecm_pkg::ST_CMP: n_state = r_pt ? ecm_pkg::ST_WB : ecm_pkg::ST_MX;
            ecm_pkg::ST_WB:  n_state = last_j ? ecm_pkg::ST_APP : ecm_pkg::ST_RD;
            ecm_pkg::ST_APP: begin
                if (r_pt) begin
                    n_state = r_last ? ecm_pkg::ST_ORD : ecm_pkg::ST_IDLE;
                end
            end
            ecm_pkg::ST_ORD: n_state = ecm_pkg::ST_OWAIT;
            ecm_pkg::ST_OWAIT: begin
                if (o_corner.ready) begin
                    n_state = r_o_last ? ecm_pkg::ST_IDLE : ecm_pkg::ST_ORD;
                end
            end
            default: n_state = ecm_pkg::ST_IDLE;
        endcase
    end

    // Handshake and unit controls.
    always_comb begin
        i_seg.ready    = (r_state == ecm_pkg::ST_IDLE);
        i_cfg.ready    = 1'b1;
        o_corner.valid = (r_state == ecm_pkg::ST_OWAIT);
        sq_start       = (r_state == ecm_pkg::ST_MS) && r_rng_mode;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ecm_pkg::ST_IDLE;
            r_radius   <= ecm_pkg::RADIUS_RESET;
            r_count    <= '0;
            r_n        <= '0;
            r_j        <= '0;
            r_pt       <= 1'b0;
            r_rng_mode <= 1'b1;
            r_hit_s    <= 1'b0;
            r_hit_e    <= 1'b0;
            r_ovf      <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_radius <= i_cfg.merge_radius;
            end
            unique case (r_state)
                ecm_pkg::ST_IDLE: begin
                    if (seg_beat) begin
                        r_last     <= i_seg.last_segment;
                        r_pt       <= 1'b0;
                        r_rng_mode <= 1'b1;
                        r_hit_s    <= 1'b0;
                        r_hit_e    <= 1'b0;
                        r_n        <= r_count;
                        r_j        <= '0;
                    end
                end
                ecm_pkg::ST_SQRT: begin
                    if (sq_done) begin
                        if (!r_pt) begin
                            r_pt <= 1'b1;
                        end else begin
                            r_pt       <= 1'b0;
                            r_rng_mode <= 1'b0;
                            r_j        <= '0;
                        end
                    end
                end
                ecm_pkg::ST_CMP: begin
                    if (hit) begin
                        if (r_pt) begin
                            r_hit_e <= 1'b1;
                        end else begin
                            r_hit_s <= 1'b1;
                        end
                    end
                    r_pt <= ~r_pt;
                end
                ecm_pkg::ST_WB: begin
                    r_pt <= 1'b0;
                    if (!last_j) begin
                        r_j <= r_j + CW'(1);
                    end
                end
                ecm_pkg::ST_APP: begin
                    if (!hit_pt) begin
                        if (r_count < CNT_MAX) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_pt <= 1'b1;
                    r_j  <= '0;
                end
                ecm_pkg::ST_OWAIT: begin
                    if (out_beat) begin
                        if (r_o_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_j <= r_j + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath, corner table and output register.
    always_ff @(posedge i_clk) begin
        r_prod <= ecm_pkg::PROD_W'(mul_op) * ecm_pkg::PROD_W'(mul_op);
        unique case (r_state)
            ecm_pkg::ST_IDLE: begin
                if (seg_beat) begin
                    r_sx <= i_seg.start_x;
                    r_sy <= i_seg.start_y;
                    r_ex <= i_seg.end_x;
                    r_ey <= i_seg.end_y;
                end
            end
            ecm_pkg::ST_R2L: r_r2  <= r_prod[R2_W-1:0];
            ecm_pkg::ST_MY:  r_acc <= unsigned'(r_prod);
            ecm_pkg::ST_MS:  r_acc <= sq_sum;
            ecm_pkg::ST_SQRT: begin
                if (sq_done) begin
                    if (r_pt) begin
                        r_rng_e <= sq_root;
                    end else begin
                        r_rng_s <= sq_root;
                    end
                end
            end
            ecm_pkg::ST_RD: begin
                {r_cx, r_cy, r_cs} <= r_mem[r_j[IW-1:0]];
            end
            ecm_pkg::ST_CMP: begin
                // The end point sees the corner as the start point left it.
                if (hit) begin
                    r_cx <= mid_sx[CX_W-1:1];
                    r_cy <= mid_sy[CX_W-1:1];
                    r_cs <= sat_sum;
                end
            end
            ecm_pkg::ST_WB: begin
                r_mem[r_j[IW-1:0]] <= '{x: r_cx, y: r_cy, sum: r_cs};
            end
            ecm_pkg::ST_APP: begin
                if (!hit_pt && (r_count < CNT_MAX)) begin
                    r_mem[r_count[IW-1:0]] <= '{
                        x: pt_x, y: pt_y, sum: ecm_pkg::RANGE_W'(rng_pt)
                    };
                end
            end
            ecm_pkg::ST_ORD: begin
                r_o_ovf <= r_ovf;
                if (r_count == '0) begin
                    r_o_x     <= '0;
                    r_o_y     <= '0;
                    r_o_sum   <= '0;
                    r_o_last  <= 1'b1;
                    r_o_empty <= 1'b1;
                end else begin
                    {r_o_x, r_o_y, r_o_sum} <= r_mem[r_j[IW-1:0]];
                    r_o_last  <= (r_j == (r_count - CW'(1)));
                    r_o_empty <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_corner.corner_x       = r_o_x;
    assign o_corner.corner_y       = r_o_y;
    assign o_corner.range_sum      = r_o_sum;
    assign o_corner.last_corner    = r_o_last;
    assign o_corner.frame_empty    = r_o_empty;
    assign o_corner.table_overflow = r_o_ovf;

    `ECM_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_MAX, "corner count beyond table depth")
    `ECM_ASSERT_NEXT(a_seg_starts, seg_beat && !i_seg.no_segment, r_state == ecm_pkg::ST_R2, "segment beat did not start the range sequence")
    `ECM_ASSERT_NEXT(a_frame_clear, out_beat && o_corner.last_corner, (r_count == '0) && !r_ovf, "table not cleared after the last corner beat")
    `ECM_ASSERT_IMPL(a_wb_index, r_state == ecm_pkg::ST_WB, r_j < r_n, "write-back beyond corners held at arrival")

endmodule

`default_nettype wire

// ===== src/ecm_isqrt.sv =====
`default_nettype none

// Restoring integer square root, one result bit per cycle.
module ecm_isqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ecm_pkg::SQ_W-1:0]  i_value,
    output ecm_pkg::t_root                 o_root,
    output logic                           o_done
);

    localparam int RW = ecm_pkg::ROOT_W + 3;
    localparam int IW = $clog2(ecm_pkg::ROOT_W);

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_i;
    logic [ecm_pkg::SQ_W-1:0] r_val;
    logic [RW-1:0]            r_rem;
    ecm_pkg::t_root           r_root;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          fits;

    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_val[ecm_pkg::SQ_W-1 -: 2]};
        trial  = RW'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + IW'(1);
                if (r_i == IW'(ecm_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ecm_pkg::ROOT_W-2:0], fits};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire
